// ----- rtl/core/yuv420_pair_to_rgb888_defines.svh -----
// Assertion macros shared by the YUV420 pair to RGB888 converter.
// No dependencies; the using module must provide clk and rst_n in scope.
`ifndef YUV420_PAIR_TO_RGB888_DEFINES_SVH
`define YUV420_PAIR_TO_RGB888_DEFINES_SVH

// Consequence must hold in the same cycle as the condition.
`define YPRGB_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the sequence ends.
`define YPRGB_ASSERT_NEXT(lbl, seq, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) seq |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/yprgb_pkg.sv -----
// Shared types and constants of the YUV420 pair to RGB888 converter.
// No dependencies.
package yprgb_pkg;

  // Fixed-point coefficients, scaled by 256.
  localparam logic signed [9:0] K_RV = 10'sd359;
  localparam logic signed [9:0] K_GV = 10'sd183;
  localparam logic signed [9:0] K_GU = 10'sd88;
  localparam logic signed [9:0] K_BU = 10'sd454;

  // Width of the scaled chroma products and of the luma plus offset sums.
  localparam int unsigned PROD_W = 17;
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned FRAC_W = 8;

  // One accepted pixel pair.
  typedef struct packed {
    logic [7:0] luma_even;
    logic [7:0] luma_odd;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } pair_in_t;

  // After the multiply stage: lumas and the three scaled offsets.
  typedef struct packed {
    logic [7:0]               luma_even;
    logic [7:0]               luma_odd;
    logic signed [PROD_W-1:0] red_prod;
    logic signed [PROD_W-1:0] green_prod;
    logic signed [PROD_W-1:0] blue_prod;
  } prod_t;

  // After the add stage: unclamped channel values.
  typedef struct packed {
    logic signed [SUM_W-1:0] red_even;
    logic signed [SUM_W-1:0] green_even;
    logic signed [SUM_W-1:0] blue_even;
    logic signed [SUM_W-1:0] red_odd;
    logic signed [SUM_W-1:0] green_odd;
    logic signed [SUM_W-1:0] blue_odd;
  } sum_t;

  // Final saturated pixel pair.
  typedef struct packed {
    logic [7:0] red_even;
    logic [7:0] green_even;
    logic [7:0] blue_even;
    logic [7:0] red_odd;
    logic [7:0] green_odd;
    logic [7:0] blue_odd;
  } rgb_pair_t;

endpackage

// ----- rtl/core/yprgb_mul_stage.sv -----
// First pipeline stage: recenters chroma and forms the scaled offsets.
// Depends on yprgb_pkg.
module yprgb_mul_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  yprgb_pkg::pair_in_t in_data,
  output logic              out_vld,
  input  logic              out_rdy,
  output yprgb_pkg::prod_t  out_data
);

  logic                         vld_r;
  logic                         vld_nxt;
  yprgb_pkg::prod_t             data_r;
  yprgb_pkg::prod_t             data_nxt;
  logic signed [7:0]            u_s;
  logic signed [7:0]            v_s;
  logic signed [yprgb_pkg::PROD_W:0] red_wide;
  logic signed [yprgb_pkg::PROD_W:0] green_wide;
  logic signed [yprgb_pkg::PROD_W:0] blue_wide;

  // The stage takes a new item when empty or when its item moves on.
  assign in_rdy  = !vld_r || out_rdy;
  assign vld_nxt = in_rdy ? in_vld : vld_r;

  // Subtracting 128 from an offset-binary byte flips its top bit.
  always_comb begin
    u_s = {~in_data.chroma_blue[7], in_data.chroma_blue[6:0]};
    v_s = {~in_data.chroma_red[7], in_data.chroma_red[6:0]};
    red_wide   = 18'(v_s) * 18'(yprgb_pkg::K_RV);
    green_wide = 18'(v_s) * 18'(yprgb_pkg::K_GV) + 18'(u_s) * 18'(yprgb_pkg::K_GU);
    blue_wide  = 18'(u_s) * 18'(yprgb_pkg::K_BU);
    data_nxt.luma_even  = in_data.luma_even;
    data_nxt.luma_odd   = in_data.luma_odd;
    data_nxt.red_prod   = red_wide[yprgb_pkg::PROD_W-1:0];
    data_nxt.green_prod = green_wide[yprgb_pkg::PROD_W-1:0];
    data_nxt.blue_prod  = blue_wide[yprgb_pkg::PROD_W-1:0];
  end

  // Valid bit with reset; payload loads only on acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ----- rtl/core/yprgb_add_stage.sv -----
// Second pipeline stage: floors the offsets and applies them to both lumas.
// Depends on yprgb_pkg.
module yprgb_add_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  output logic             in_rdy,
  input  yprgb_pkg::prod_t in_data,
  output logic             out_vld,
  input  logic             out_rdy,
  output yprgb_pkg::sum_t  out_data
);

  localparam int unsigned SUM_W = yprgb_pkg::SUM_W;

  logic                     vld_r;
  logic                     vld_nxt;
  yprgb_pkg::sum_t          data_r;
  yprgb_pkg::sum_t          data_nxt;
  logic signed [SUM_W-1:0]  rd;
  logic signed [SUM_W-1:0]  gd;
  logic signed [SUM_W-1:0]  bd;
  logic signed [SUM_W-1:0]  ye;
  logic signed [SUM_W-1:0]  yo;

  assign in_rdy  = !vld_r || out_rdy;
  assign vld_nxt = in_rdy ? in_vld : vld_r;

  // Arithmetic shift floors toward minus infinity, then luma plus offset.
  always_comb begin
    rd = SUM_W'(in_data.red_prod >>> yprgb_pkg::FRAC_W);
    gd = SUM_W'(in_data.green_prod >>> yprgb_pkg::FRAC_W);
    bd = SUM_W'(in_data.blue_prod >>> yprgb_pkg::FRAC_W);
    ye = $signed({2'b00, in_data.luma_even});
    yo = $signed({2'b00, in_data.luma_odd});
    data_nxt.red_even   = ye + rd;
    data_nxt.green_even = ye - gd;
    data_nxt.blue_even  = ye + bd;
    data_nxt.red_odd    = yo + rd;
    data_nxt.green_odd  = yo - gd;
    data_nxt.blue_odd   = yo + bd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ----- rtl/core/yprgb_clamp_stage.sv -----
// Third pipeline stage: saturates every channel to 0..255 into the output register.
// Depends on yprgb_pkg.
module yprgb_clamp_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  output logic                 in_rdy,
  input  yprgb_pkg::sum_t      in_data,
  output logic                 out_vld,
  input  logic                 out_rdy,
  output yprgb_pkg::rgb_pair_t out_data
);

  logic                 vld_r;
  logic                 vld_nxt;
  yprgb_pkg::rgb_pair_t data_r;
  yprgb_pkg::rgb_pair_t data_nxt;

  // Negative values go to zero, values past 255 go to 255.
  function automatic logic [7:0] sat8(input logic signed [yprgb_pkg::SUM_W-1:0] s);
    logic [7:0] res;
    if (s[yprgb_pkg::SUM_W-1]) begin
      res = 8'd0;
    end else if (s[yprgb_pkg::SUM_W-2:8] != '0) begin
      res = 8'hFF;
    end else begin
      res = s[7:0];
    end
    return res;
  endfunction

  assign in_rdy  = !vld_r || out_rdy;
  assign vld_nxt = in_rdy ? in_vld : vld_r;

  always_comb begin
    data_nxt.red_even   = sat8(in_data.red_even);
    data_nxt.green_even = sat8(in_data.green_even);
    data_nxt.blue_even  = sat8(in_data.blue_even);
    data_nxt.red_odd    = sat8(in_data.red_odd);
    data_nxt.green_odd  = sat8(in_data.green_odd);
    data_nxt.blue_odd   = sat8(in_data.blue_odd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ----- rtl/core/yuv420_pair_to_rgb888.sv -----
// Path: an accepted item passes the multiply, add and clamp stage registers to the out_ port.
// Throughput: one pixel pair per cycle while out_stall is low; each of the three stages holds
// one item and moves on when the next stage is empty or draining.
// Reset: synchronous, active low; clears the stage valid bits only.
// Depends on yprgb_pkg, the three stage modules and the assertion header.
`include "yuv420_pair_to_rgb888_defines.svh"

module yuv420_pair_to_rgb888 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_luma_even,
  input  logic [7:0] in_luma_odd,
  input  logic [7:0] in_chroma_blue,
  input  logic [7:0] in_chroma_red,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_even,
  output logic [7:0] out_green_even,
  output logic [7:0] out_blue_even,
  output logic [7:0] out_red_odd,
  output logic [7:0] out_green_odd,
  output logic [7:0] out_blue_odd
);

  yprgb_pkg::pair_in_t  pair_in;
  yprgb_pkg::prod_t     prod;
  yprgb_pkg::sum_t      sum;
  yprgb_pkg::rgb_pair_t rgb;
  logic                 in_rdy;
  logic                 prod_vld;
  logic                 prod_rdy;
  logic                 sum_vld;
  logic                 sum_rdy;

  assign pair_in.luma_even   = in_luma_even;
  assign pair_in.luma_odd    = in_luma_odd;
  assign pair_in.chroma_blue = in_chroma_blue;
  assign pair_in.chroma_red  = in_chroma_red;
  assign in_stall            = !in_rdy;

  // Chroma recentering and constant multiplies.
  yprgb_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_valid),
    .in_rdy   (in_rdy),
    .in_data  (pair_in),
    .out_vld  (prod_vld),
    .out_rdy  (prod_rdy),
    .out_data (prod)
  );

  // Offset flooring and luma addition.
  yprgb_add_stage u_add (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (prod_vld),
    .in_rdy   (prod_rdy),
    .in_data  (prod),
    .out_vld  (sum_vld),
    .out_rdy  (sum_rdy),
    .out_data (sum)
  );

  // Saturation into the output register.
  yprgb_clamp_stage u_clamp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sum_vld),
    .in_rdy   (sum_rdy),
    .in_data  (sum),
    .out_vld  (out_valid),
    .out_rdy  (!out_stall),
    .out_data (rgb)
  );

  assign out_red_even   = rgb.red_even;
  assign out_green_even = rgb.green_even;
  assign out_blue_even  = rgb.blue_even;
  assign out_red_odd    = rgb.red_odd;
  assign out_green_odd  = rgb.green_odd;
  assign out_blue_odd   = rgb.blue_odd;

  // The input backs up only when every stage is full and the output is held.
  `YPRGB_ASSERT_NOW(a_stall_only_full, in_stall, out_valid && out_stall && sum_vld && prod_vld, "input stalled while the pipeline has room")

  // An accepted item reaches the output through the add and clamp stages when nothing holds it.
  `YPRGB_ASSERT_NEXT(a_latency_three, ((in_valid && !in_stall) ##1 !out_stall ##1 !out_stall), out_valid, "accepted item did not arrive within three cycles")

  // A full middle stage that cannot drain keeps its item.
  `YPRGB_ASSERT_NEXT(a_mid_holds, (sum_vld && !sum_rdy), sum_vld, "held item dropped from the add stage")

endmodule
